// ===== rtl/core/ctc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache trailer checker package
// Beat types, status codes, trailer layout constants and the FNV-1a helpers
// shared by the checker modules.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // Trailer layout.
  localparam int unsigned TRAILER_BYTES_DEF = 32;
  localparam int unsigned POS_W             = 7;
  localparam int unsigned MAGIC_LEN         = 8;
  localparam int unsigned CRC_AT            = 24;
  localparam int unsigned SUM_AT            = 28;
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  // Word slots, indexed by byte position divided by four.
  localparam logic [POS_W-3:0] SLOT_SIZE  = (POS_W-2)'(2);
  localparam logic [POS_W-3:0] SLOT_START = (POS_W-2)'(3);
  localparam logic [POS_W-3:0] SLOT_TEXT  = (POS_W-2)'(4);
  localparam logic [POS_W-3:0] SLOT_BOOK  = (POS_W-2)'(5);
  localparam logic [POS_W-3:0] SLOT_CRC   = (POS_W-2)'(CRC_AT / 4);
  localparam logic [POS_W-3:0] SLOT_SUM   = (POS_W-2)'(SUM_AT / 4);

  // FNV-1a 32 constants.
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Result status, in the order the checks are made.
  typedef enum logic [2:0] {
    STATUS_OK     = 3'd0,
    STATUS_LENGTH = 3'd1,
    STATUS_MAGIC  = 3'd2,
    STATUS_SIZE   = 3'd3,
    STATUS_SUM    = 3'd4,
    STATUS_BOUNDS = 3'd5
  } status_e;

  // One input beat.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] expected_payload;
    logic        final_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] start_offset;
    logic [31:0] text_length;
    logic [31:0] book_length;
    logic [31:0] text_checksum;
  } out_beat_t;

  // Expected magic byte at a given position of the magic field.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h47;
      3'd1:    b = 8'h42;
      3'd2:    b = 8'h41;
      3'd3:    b = 8'h52;
      3'd4:    b = 8'h43;
      3'd5:    b = 8'h48;
      3'd6:    b = 8'h45;
      3'd7:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One FNV-1a step. The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1, so the
  // multiply is a sum of shifted copies.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

// ===== rtl/core/cache_trailer_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache trailer checker
// Checks a cache trailer streamed one byte per beat and reports one result.
// ----------------------------------------------------------------------------
// The block takes one trailer byte per cycle while no final byte waits. Every
// beat passes an input register, then the checking logic and, for the final
// byte, the result register, which holds the result until it is taken.
// Non-final bytes flow at one per cycle whatever the output side does; only a
// final byte waits, while the result register still holds an untaken result.
// The TRAILER_BYTES parameter sets the expected trailer length (32 to 126).
module cache_trailer_checker_unit import ctc_pkg::*; #(
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic             stage_valid;
  in_beat_t         stage_beat;
  logic             fire;
  logic             out_space;
  out_beat_t        result;
  logic [POS_W-1:0] pos;

  // A held beat moves on unless it is final and the result register is busy.
  assign fire = stage_valid && (!stage_beat.final_byte || out_space);

  ctc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .take_i     (fire),
    .valid_o    (stage_valid),
    .beat_o     (stage_beat)
  );

  ctc_engine #(
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (stage_beat),
    .result_o (result),
    .pos_o    (pos)
  );

  ctc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && stage_beat.final_byte),
    .result_i    (result),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // A final byte restarts the byte count for the next trailer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stage_beat.final_byte |=> pos == '0)
    else $error("byte count not cleared after final byte");

  // A final byte is never taken while the result register cannot load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stage_beat.final_byte |-> !out_valid_o || out_ready_i)
    else $error("result register overwritten");

  // An ok result always carries a nonzero text length within the book.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status == STATUS_OK |->
      out_beat_o.text_length != 32'd0 &&
      out_beat_o.start_offset <= out_beat_o.book_length)
    else $error("ok status with bad bounds");

endmodule

// ===== rtl/core/ctc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache trailer checker input stage
// Registers one input beat and releases it when the engine takes it.
// ----------------------------------------------------------------------------
module ctc_in_stage import ctc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_beat_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  // The register can load when empty or when its beat leaves this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/ctc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache trailer checker engine
// Holds the per-trailer state: byte count, magic flag, captured words and the
// running FNV-1a hash. Builds the result on the final byte.
// ----------------------------------------------------------------------------
module ctc_engine import ctc_pkg::*; #(
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_beat_t         beat_i,
  output out_beat_t        result_o,
  output logic [POS_W-1:0] pos_o
);

  localparam logic [POS_W-1:0] TRAILER_LEN  = POS_W'(TRAILER_BYTES);
  localparam logic [31:0]      TRAILER_SIZE = 32'(TRAILER_BYTES);
  localparam logic [POS_W-1:0] MAGIC_END    = POS_W'(MAGIC_LEN);
  localparam logic [POS_W-1:0] SUM_START    = POS_W'(SUM_AT);
  localparam logic [POS_W-1:0] SUM_END      = POS_W'(SUM_AT + 4);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      hash_q, hash_d;
  logic             magic_q, magic_d;
  logic [31:0]      size_q, size_d;
  logic [31:0]      start_q, start_d;
  logic [31:0]      text_q, text_d;
  logic [31:0]      book_q, book_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      sum_q, sum_d;

  logic [7:0]       b;
  logic [4:0]       lane_sh;
  logic             in_body;
  logic             bounds_bad;
  status_e          status;

  assign b       = beat_i.data_byte;
  assign lane_sh = {pos_q[1:0], 3'b000};
  assign in_body = pos_q < TRAILER_LEN;

  // Next state after this byte.
  always_comb begin
    size_d  = size_q;
    start_d = start_q;
    text_d  = text_q;
    book_d  = book_q;
    crc_d   = crc_q;
    sum_d   = sum_q;
    magic_d = magic_q;
    hash_d  = hash_q;
    if (in_body) begin
      if (pos_q < MAGIC_END && b != magic_byte(pos_q[2:0])) begin
        magic_d = 1'b0;
      end
      case (pos_q[POS_W-1:2])
        SLOT_SIZE:  size_d[lane_sh +: 8]  = b;
        SLOT_START: start_d[lane_sh +: 8] = b;
        SLOT_TEXT:  text_d[lane_sh +: 8]  = b;
        SLOT_BOOK:  book_d[lane_sh +: 8]  = b;
        SLOT_CRC:   crc_d[lane_sh +: 8]   = b;
        SLOT_SUM:   sum_d[lane_sh +: 8]   = b;
        default: ;
      endcase
      // The stored checksum word itself is left out of the hash.
      if (pos_q < SUM_START || pos_q >= SUM_END) begin
        hash_d = fnv_step(hash_q, b);
      end
    end
    pos_d = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;
  end

  // Checks in priority order, on the state after this byte.
  assign bounds_bad = (text_d == 32'd0) || (book_d != beat_i.expected_payload) ||
                      (start_d > book_d) || (text_d > book_d - start_d);

  always_comb begin
    if (pos_d != TRAILER_LEN) begin
      status = STATUS_LENGTH;
    end else if (!magic_d) begin
      status = STATUS_MAGIC;
    end else if (size_d != TRAILER_SIZE) begin
      status = STATUS_SIZE;
    end else if (sum_d != hash_d) begin
      status = STATUS_SUM;
    end else if (bounds_bad) begin
      status = STATUS_BOUNDS;
    end else begin
      status = STATUS_OK;
    end
  end

  assign result_o.status        = status;
  assign result_o.start_offset  = start_d;
  assign result_o.text_length   = text_d;
  assign result_o.book_length   = book_d;
  assign result_o.text_checksum = crc_d;

  // State update; the final byte returns everything to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hash_q  <= HASH_BASIS;
      magic_q <= 1'b1;
      size_q  <= '0;
      start_q <= '0;
      text_q  <= '0;
      book_q  <= '0;
      crc_q   <= '0;
      sum_q   <= '0;
    end else if (fire_i) begin
      if (beat_i.final_byte) begin
        pos_q   <= '0;
        hash_q  <= HASH_BASIS;
        magic_q <= 1'b1;
        size_q  <= '0;
        start_q <= '0;
        text_q  <= '0;
        book_q  <= '0;
        crc_q   <= '0;
        sum_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        hash_q  <= hash_d;
        magic_q <= magic_d;
        size_q  <= size_d;
        start_q <= start_d;
        text_q  <= text_d;
        book_q  <= book_d;
        crc_q   <= crc_d;
        sum_q   <= sum_d;
      end
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/core/ctc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache trailer checker output stage
// Result register holding one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ctc_out_stage import ctc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_beat_t result_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  // Room for a new result when empty or when the held one leaves now.
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule
